// ===== design/c1d_pkg.sv =====
// Shared constants, opcodes and controller/datapath interface types for the conv1d layer.
`default_nettype none

package c1d_pkg;

	localparam int DATA_W      = 16;
	localparam int FIDX_W      = 5;
	localparam int TIDX_W      = 3;
	localparam int POS_W       = 10;
	localparam int ACT_W       = 15;
	localparam int FRAC_W      = 5;
	localparam int APB_DATA_W  = 32;
	localparam int APB_ADDR_W  = 3;

	localparam int DEF_NUM_FILTERS = 32;
	localparam int DEF_NUM_TAPS    = 5;
	localparam int DEF_MAX_LENGTH  = 1024;

	localparam logic [FRAC_W-1:0] FRAC_RESET = 5'd8;

	// register word index (byte address / 4)
	localparam logic [0:0] REG_FRAC_SHIFT = 1'b0;

	localparam logic [1:0] OP_WEIGHT = 2'd0;
	localparam logic [1:0] OP_BIAS   = 2'd1;
	localparam logic [1:0] OP_SAMPLE = 2'd2;
	localparam logic [1:0] OP_END    = 2'd3;

	typedef struct packed {
		logic wr_weight;
		logic wr_bias;
		logic take_sample;
		logic end_first;
		logic end_next;
		logic clear;
		logic issue;
		logic issue_last;
	} cmd_t;

	typedef struct packed {
		logic cnt_full;
		logic cnt_ge_pad;
		logic cnt_zero;
		logic end_last;
		logic s1_busy;
		logic adv;
	} sts_t;

endpackage

`default_nettype wire

// ===== design/c1d_dp.sv =====
// Datapath: sample window, weight/bias memories, MAC pipeline and output register.
`default_nettype none

module c1d_dp #(
	parameter int NUM_FILTERS = c1d_pkg::DEF_NUM_FILTERS,
	parameter int NUM_TAPS    = c1d_pkg::DEF_NUM_TAPS,
	parameter int MAX_LENGTH  = c1d_pkg::DEF_MAX_LENGTH,
	localparam int FW = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  c1d_pkg::cmd_t                     cmd,
	output c1d_pkg::sts_t                     sts,
	input  wire  [FW-1:0]                     issue_filter,
	input  wire  [c1d_pkg::FIDX_W-1:0]        filter_index,
	input  wire  [c1d_pkg::TIDX_W-1:0]        tap_index,
	input  wire  signed [c1d_pkg::DATA_W-1:0] data_value,
	input  wire  [c1d_pkg::FRAC_W-1:0]        frac_shift,
	output logic                              out_valid,
	input  wire                               out_ready,
	output logic [c1d_pkg::FIDX_W-1:0]        filter_out,
	output logic [c1d_pkg::POS_W-1:0]         position,
	output logic [c1d_pkg::ACT_W-1:0]         activation,
	output logic                              last_of_run
);

	localparam int DW    = c1d_pkg::DATA_W;
	localparam int PW    = c1d_pkg::POS_W;
	localparam int FOW   = c1d_pkg::FIDX_W;
	localparam int AW    = c1d_pkg::ACT_W;
	localparam int TW    = $clog2(NUM_TAPS);
	localparam int WIN   = NUM_TAPS - 1;
	localparam int PAD   = (NUM_TAPS - 1) / 2;
	localparam int OFF   = WIN - 2 * PAD;
	localparam int JW    = $clog2(PAD + 1);
	localparam int CNT_W = $clog2(MAX_LENGTH + 1);
	localparam int PRD_W = 2 * DW;
	localparam int ACC_W = PRD_W + $clog2(NUM_TAPS);

	logic [CNT_W-1:0]    cnt_q;
	logic signed [DW-1:0] win_q [WIN];
	logic [JW-1:0]       end_j_q;
	logic [JW-1:0]       j0;
	logic [JW-1:0]       jn;
	logic signed [DW-1:0] taps_q [NUM_TAPS];
	logic signed [DW-1:0] taps_end [NUM_TAPS];
	logic [CNT_W-1:0]    pos_q;
	logic                adv;
	logic                w_ok;
	logic                b_ok;

	logic signed [DW-1:0] wmem [NUM_FILTERS][NUM_TAPS];
	logic signed [DW-1:0] bmem [NUM_FILTERS];

	logic                 v_s1, v_s2, v_s3, v_s4;
	logic [FW-1:0]        f_s1, f_s2, f_s3, f_s4;
	logic [CNT_W-1:0]     pos_s1, pos_s2, pos_s3, pos_s4;
	logic                 last_s1, last_s2, last_s3, last_s4;
	logic signed [DW-1:0] wrow_s1 [NUM_TAPS];
	logic signed [DW-1:0] bias_s1, bias_s2, bias_s3, bias_s4;
	logic signed [PRD_W-1:0] prod_s2 [NUM_TAPS];
	logic signed [ACC_W-1:0] acc_s3;
	logic signed [DW-1:0]  sat_s4;

	logic signed [ACC_W-1:0] acc_sum;
	logic signed [ACC_W-1:0] shifted;
	logic signed [DW-1:0]    sat_n;
	logic signed [DW:0]      biased;
	logic [AW-1:0]           act_n;

	logic                 out_valid_q;
	logic [FOW-1:0]       filter_out_q;
	logic [PW-1:0]        position_q;
	logic [AW-1:0]        activation_q;
	logic                 last_q;

	assign adv  = !out_valid_q || out_ready;
	assign w_ok = (32'(filter_index) < NUM_FILTERS) && (32'(tap_index) < NUM_TAPS);
	assign b_ok = 32'(filter_index) < NUM_FILTERS;
	assign j0   = (32'(cnt_q) >= PAD) ? '0 : JW'(PAD - 32'(cnt_q));
	assign jn   = cmd.end_first ? j0 : JW'(end_j_q + 1'b1);

	assign sts.cnt_full   = 32'(cnt_q) >= MAX_LENGTH;
	assign sts.cnt_ge_pad = 32'(cnt_q) >= PAD;
	assign sts.cnt_zero   = cnt_q == '0;
	assign sts.end_last   = end_j_q == JW'(PAD - 1);
	assign sts.s1_busy    = v_s1;
	assign sts.adv        = adv;

	// End-of-sequence taps: step j covers position cnt-PAD+j; slots past the
	// newest sample read as zero.
	always_comb begin
		for (int k = 0; k < NUM_TAPS; k++) begin
			taps_end[k] = '0;
			for (int j = 0; j < PAD; j++) begin
				if (jn == JW'(j) && (j + k + OFF) < WIN)
					taps_end[k] = win_q[((j + k + OFF) < WIN) ? (j + k + OFF) : 0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			end_j_q <= '0;
			for (int k = 0; k < WIN; k++)
				win_q[k] <= '0;
		end else begin
			if (cmd.clear) begin
				cnt_q <= '0;
				for (int k = 0; k < WIN; k++)
					win_q[k] <= '0;
			end else if (cmd.take_sample) begin
				cnt_q <= cnt_q + 1'b1;
				for (int k = 0; k + 1 < WIN; k++)
					win_q[k] <= win_q[k + 1];
				win_q[WIN - 1] <= data_value;
			end
			if (cmd.end_first || cmd.end_next)
				end_j_q <= jn;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_sample) begin
			for (int k = 0; k < WIN; k++)
				taps_q[k] <= win_q[k];
			taps_q[WIN] <= data_value;
			pos_q       <= cnt_q - CNT_W'(PAD);
		end else if (cmd.end_first || cmd.end_next) begin
			for (int k = 0; k < NUM_TAPS; k++)
				taps_q[k] <= taps_end[k];
			pos_q <= cnt_q + CNT_W'(jn) - CNT_W'(PAD);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_weight && w_ok)
			wmem[FW'(filter_index)][TW'(tap_index)] <= data_value;
		if (cmd.wr_bias && b_ok)
			bmem[FW'(filter_index)] <= data_value;
		if (adv) begin
			wrow_s1 <= wmem[issue_filter];
			bias_s1 <= bmem[issue_filter];
		end
	end

	always_comb begin
		acc_sum = '0;
		for (int k = 0; k < NUM_TAPS; k++)
			acc_sum = acc_sum + ACC_W'(prod_s2[k]);
	end

	// floor shift, then saturate to 16 bits before the bias
	always_comb begin
		shifted = acc_s3 >>> frac_shift;
		if (shifted > ACC_W'(32767))
			sat_n = 16'sh7fff;
		else if (shifted < -ACC_W'(32768))
			sat_n = -16'sh8000;
		else
			sat_n = DW'(shifted);
	end

	always_comb begin
		biased = {sat_s4[DW-1], sat_s4} + {bias_s4[DW-1], bias_s4};
		if (biased[DW])
			act_n = '0;
		else if (biased[DW-1])
			act_n = '1;
		else
			act_n = biased[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= cmd.issue;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s1    <= issue_filter;
			pos_s1  <= pos_q;
			last_s1 <= cmd.issue_last;

			for (int k = 0; k < NUM_TAPS; k++)
				prod_s2[k] <= taps_q[k] * wrow_s1[k];
			bias_s2 <= bias_s1;
			f_s2    <= f_s1;
			pos_s2  <= pos_s1;
			last_s2 <= last_s1;

			acc_s3  <= acc_sum;
			bias_s3 <= bias_s2;
			f_s3    <= f_s2;
			pos_s3  <= pos_s2;
			last_s3 <= last_s2;

			sat_s4  <= sat_n;
			bias_s4 <= bias_s3;
			f_s4    <= f_s3;
			pos_s4  <= pos_s3;
			last_s4 <= last_s3;

			filter_out_q <= FOW'(f_s4);
			position_q   <= PW'(pos_s4);
			activation_q <= act_n;
			last_q       <= last_s4;
		end
	end

	assign out_valid   = out_valid_q;
	assign filter_out  = filter_out_q;
	assign position    = position_q;
	assign activation  = activation_q;
	assign last_of_run = last_q;

endmodule

`default_nettype wire

// ===== design/c1d_ctrl.sv =====
// Controller: request decode, filter issue sequencing and end-of-sequence stepping.
`default_nettype none

module c1d_ctrl #(
	parameter int NUM_FILTERS = c1d_pkg::DEF_NUM_FILTERS,
	localparam int FW = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  wire  [1:0]            opcode,
	output c1d_pkg::cmd_t         cmd,
	input  c1d_pkg::sts_t         sts,
	output logic [FW-1:0]         issue_filter
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_ISSUE = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;

	localparam logic [FW-1:0] F_LAST = FW'(NUM_FILTERS - 1);

	logic [1:0]    state_q;
	logic [1:0]    state_n;
	logic [FW-1:0] f_q;
	logic [FW-1:0] f_n;
	logic          end_q;
	logic          end_n;

	assign in_ready     = state_q == S_IDLE;
	assign issue_filter = f_q;

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		f_n     = f_q;
		end_n   = end_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (opcode)
						c1d_pkg::OP_WEIGHT: cmd.wr_weight = 1'b1;
						c1d_pkg::OP_BIAS:   cmd.wr_bias = 1'b1;
						c1d_pkg::OP_SAMPLE: begin
							if (!sts.cnt_full) begin
								cmd.take_sample = 1'b1;
								if (sts.cnt_ge_pad) begin
									end_n   = 1'b0;
									state_n = S_ISSUE;
								end
							end
						end
						c1d_pkg::OP_END: begin
							if (sts.cnt_zero) begin
								cmd.clear = 1'b1;
							end else begin
								cmd.end_first = 1'b1;
								end_n         = 1'b1;
								state_n       = S_ISSUE;
							end
						end
						default: ;
					endcase
				end
			end
			S_ISSUE: begin
				cmd.issue      = sts.adv;
				cmd.issue_last = sts.adv && (f_q == F_LAST) && (!end_q || sts.end_last);
				if (sts.adv) begin
					if (f_q == F_LAST) begin
						f_n     = '0;
						state_n = S_DRAIN;
					end else begin
						f_n = f_q + 1'b1;
					end
				end
			end
			S_DRAIN: begin
				// taps register is free once the last filter left stage one
				if (!sts.s1_busy) begin
					if (end_q && !sts.end_last) begin
						cmd.end_next = 1'b1;
						state_n      = S_ISSUE;
					end else begin
						cmd.clear = end_q;
						state_n   = S_IDLE;
					end
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			f_q     <= '0;
			end_q   <= 1'b0;
		end else begin
			state_q <= state_n;
			f_q     <= f_n;
			end_q   <= end_n;
		end
	end

	a_issue_only_on_adv: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> sts.adv)
		else $error("filter issued while pipeline stalled");

	a_last_filter_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ISSUE && sts.adv && f_q == F_LAST) |=>
		(state_q == S_DRAIN && f_q == '0))
		else $error("last filter issue did not enter drain");

	a_step_taps_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.end_next || cmd.end_first || cmd.take_sample) |-> !sts.s1_busy)
		else $error("taps reloaded while stage one still uses them");

	a_idle_filter_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (f_q == '0))
		else $error("filter counter not reset between requests");

	a_last_marks_end: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue_last |-> (cmd.issue && f_q == F_LAST))
		else $error("last flag on a filter that is not the final one");

endmodule

`default_nettype wire

// ===== design/conv1d_bias_relu_layer_core.sv =====
// Conv1d layer with same zero padding, bias and ReLU: top level with APB register.
//
// Input channel (in_valid/in_ready): one request carries opcode, filter_index,
// tap_index and data_value. A sample, once two (padding) samples are in, yields
// one result per filter for the position two back; an end request yields the
// remaining positions, then clears the window and count. Out-of-range loads and
// samples past MAX_LENGTH give no results.
// Output channel (out_valid/out_ready): filter_out, position, activation and
// last_of_run, set on the final result of a request.
// One filter per cycle, unless a stalled receiver holds the pipeline, goes
// through a single 5-tap multiply/sum pipeline.
// A stalled receiver freezes the whole pipeline; the output register holds
// its result, and a new request is taken once the last filter of the current
// one has left the first stage.
// Reset (arst_n low) clears window, count and pipeline and sets frac_shift to
// 8; weight and bias memories are undefined until loaded.
`default_nettype none

module conv1d_bias_relu_layer_core #(
	parameter int NUM_FILTERS = c1d_pkg::DEF_NUM_FILTERS,
	parameter int NUM_TAPS    = c1d_pkg::DEF_NUM_TAPS,
	parameter int MAX_LENGTH  = c1d_pkg::DEF_MAX_LENGTH
) (
	input  wire                                   clk,
	input  wire                                   arst_n,

	input  wire                                   psel,
	input  wire                                   penable,
	input  wire                                   pwrite,
	input  wire  [c1d_pkg::APB_ADDR_W-1:0]        paddr,
	input  wire  [c1d_pkg::APB_DATA_W-1:0]        pwdata,
	output logic [c1d_pkg::APB_DATA_W-1:0]        prdata,
	output logic                                  pready,

	input  wire                                   in_valid,
	output logic                                  in_ready,
	input  wire  [1:0]                            opcode,
	input  wire  [c1d_pkg::FIDX_W-1:0]            filter_index,
	input  wire  [c1d_pkg::TIDX_W-1:0]            tap_index,
	input  wire  signed [c1d_pkg::DATA_W-1:0]     data_value,

	output logic                                  out_valid,
	input  wire                                   out_ready,
	output logic [c1d_pkg::FIDX_W-1:0]            filter_out,
	output logic [c1d_pkg::POS_W-1:0]             position,
	output logic [c1d_pkg::ACT_W-1:0]             activation,
	output logic                                  last_of_run
);

	localparam int FW = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;
	localparam int AW = c1d_pkg::APB_ADDR_W;

	logic [c1d_pkg::FRAC_W-1:0] frac_q;
	logic                       reg_hit;
	c1d_pkg::cmd_t              cmd;
	c1d_pkg::sts_t              sts;
	logic [FW-1:0]              issue_filter;

	// word index is paddr[2]; the byte offset bits are ignored
	assign reg_hit = paddr[AW-1:2] == c1d_pkg::REG_FRAC_SHIFT;
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? c1d_pkg::APB_DATA_W'(frac_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_q <= c1d_pkg::FRAC_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			frac_q <= pwdata[c1d_pkg::FRAC_W-1:0];
		end
	end

	c1d_ctrl #(
		.NUM_FILTERS(NUM_FILTERS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.cmd         (cmd),
		.sts         (sts),
		.issue_filter(issue_filter)
	);

	c1d_dp #(
		.NUM_FILTERS(NUM_FILTERS),
		.NUM_TAPS   (NUM_TAPS),
		.MAX_LENGTH (MAX_LENGTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.issue_filter(issue_filter),
		.filter_index(filter_index),
		.tap_index   (tap_index),
		.data_value  (data_value),
		.frac_shift  (frac_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.filter_out  (filter_out),
		.position    (position),
		.activation  (activation),
		.last_of_run (last_of_run)
	);

endmodule

`default_nettype wire

// ===== tb/sv/conv1d_layer_checker.sv =====
// Checker for the conv1d layer: tracks requests, predicts activations and compares results.
module conv1d_layer_checker
	import c1d_pkg::*;
#(
	parameter int FILTERS = DEF_NUM_FILTERS,
	parameter int TAPS    = DEF_NUM_TAPS,
	parameter int MAX_LEN = DEF_MAX_LENGTH
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       psel,
	input  wire                       penable,
	input  wire                       pwrite,
	input  wire  [APB_ADDR_W-1:0]     paddr,
	input  wire  [APB_DATA_W-1:0]     pwdata,
	input  wire  [APB_DATA_W-1:0]     prdata,
	input  wire                       pready,
	input  wire                       in_valid,
	input  wire                       in_ready,
	input  wire  [1:0]                opcode,
	input  wire  [FIDX_W-1:0]         filter_index,
	input  wire  [TIDX_W-1:0]         tap_index,
	input  wire  signed [DATA_W-1:0]  data_value,
	input  wire                       out_valid,
	input  wire                       out_ready,
	input  wire  [FIDX_W-1:0]         filter_out,
	input  wire  [POS_W-1:0]          position,
	input  wire  [ACT_W-1:0]          activation,
	input  wire                       last_of_run,
	output int                        fail_count,
	output int                        pending,
	output int                        checked_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PAD = (TAPS - 1) / 2;
	localparam int WIN = TAPS - 1;

	typedef struct packed {
		logic [FIDX_W-1:0] filt;
		logic [POS_W-1:0]  pos;
		logic [ACT_W-1:0]  act;
		logic              last;
	} activation_t;

	activation_t act_q[$];

	logic signed [DATA_W-1:0] weight_mem [FILTERS*TAPS];
	logic signed [DATA_W-1:0] bias_mem [FILTERS];
	logic signed [DATA_W-1:0] window_q [WIN];
	longint                   conv_taps [TAPS];
	int                       sample_cnt;
	logic [FRAC_W-1:0]        frac_q;
	int                       fail_n;
	int                       checked_n;

	assign fail_count    = fail_n;
	assign checked_count = checked_n;

	initial begin
		fail_n    = 0;
		checked_n = 0;
		for (int i = 0; i < FILTERS*TAPS; i++) weight_mem[i] = '0;
		for (int i = 0; i < FILTERS; i++) bias_mem[i] = '0;
	end

	function automatic void note_failure(string msg);
		fail_n++;
		if (fail_n <= 10)
			$display("ERROR @%0t: %s", $realtime, msg);
	endfunction

	// one filter over conv_taps: shift, saturate, bias, ReLU clamp
	function automatic logic [ACT_W-1:0] filter_response(int f);
		longint acc;
		longint v;
		acc = 0;
		for (int k = 0; k < TAPS; k++)
			acc += conv_taps[k] * longint'(weight_mem[f*TAPS+k]);
		v = acc >>> frac_q;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		v += longint'(bias_mem[f]);
		if (v < 0) v = 0;
		if (v > 32767) v = 32767;
		return ACT_W'(v);
	endfunction

	function automatic void emit_position(int p, logic tail);
		activation_t r;
		for (int f = 0; f < FILTERS; f++) begin
			r.filt = FIDX_W'(f);
			r.pos  = POS_W'(p);
			r.act  = filter_response(f);
			r.last = tail && (f == FILTERS - 1);
			act_q.push_back(r);
		end
	endfunction

	function automatic void predict_request(logic [1:0] op, logic [FIDX_W-1:0] fi,
		logic [TIDX_W-1:0] ti, logic signed [DATA_W-1:0] d);
		int cnt;
		int first;
		int idx;
		int slot;
		case (op)
			OP_WEIGHT: begin
				if (int'(fi) < FILTERS && int'(ti) < TAPS)
					weight_mem[int'(fi)*TAPS + int'(ti)] = d;
			end
			OP_BIAS: begin
				if (int'(fi) < FILTERS)
					bias_mem[fi] = d;
			end
			OP_SAMPLE: begin
				if (sample_cnt < MAX_LEN) begin
					for (int k = 0; k < WIN; k++) conv_taps[k] = window_q[k];
					conv_taps[WIN] = d;
					if (sample_cnt >= PAD)
						emit_position(sample_cnt - PAD, 1'b1);
					for (int k = 0; k + 1 < WIN; k++) window_q[k] = window_q[k+1];
					window_q[WIN-1] = d;
					sample_cnt++;
				end
			end
			OP_END: begin
				cnt   = sample_cnt;
				first = (cnt > PAD) ? cnt - PAD : 0;
				for (int p = first; p < cnt; p++) begin
					// samples past the end of the sequence read as zero
					for (int k = 0; k < TAPS; k++) begin
						idx  = p + k - PAD;
						slot = idx - (cnt - WIN);
						if (idx < 0 || idx >= cnt || slot < 0 || slot >= WIN)
							conv_taps[k] = 0;
						else
							conv_taps[k] = window_q[slot];
					end
					emit_position(p, p == cnt - 1);
				end
				for (int k = 0; k < WIN; k++) window_q[k] = '0;
				sample_cnt = 0;
			end
		endcase
	endfunction

	always @(posedge clk) begin : watch
		activation_t got;
		activation_t want;
		if (!arst_n) begin
			for (int k = 0; k < WIN; k++) window_q[k] = '0;
			sample_cnt = 0;
			frac_q     = FRAC_RESET;
			act_q.delete();
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[APB_ADDR_W-1:2] == REG_FRAC_SHIFT)
						frac_q = pwdata[FRAC_W-1:0];
				end else if (prdata !== APB_DATA_W'(frac_q)) begin
					note_failure($sformatf("frac_shift read: expected %0d, got %0h",
						frac_q, prdata));
				end
			end
			if (in_valid && in_ready)
				predict_request(opcode, filter_index, tap_index, data_value);
			if (out_valid && out_ready) begin
				got = {filter_out, position, activation, last_of_run};
				checked_n++;
				if (act_q.size() == 0) begin
					note_failure($sformatf("unexpected result: f=%0d p=%0d a=%0d last=%0b",
						got.filt, got.pos, got.act, got.last));
				end else begin
					want = act_q.pop_front();
					if (got.filt !== want.filt || got.pos !== want.pos ||
						got.act !== want.act || got.last !== want.last)
						note_failure($sformatf(
							"result: expected f=%0d p=%0d a=%0d last=%0b, got f=%0d p=%0d a=%0d last=%0b",
							want.filt, want.pos, want.act, want.last,
							got.filt, got.pos, got.act, got.last));
				end
			end
		end
		pending <= act_q.size();
	end

endmodule

// ===== tb/sv/tb_conv1d_bias_relu_layer_core.sv =====
// Testbench top for conv1d_bias_relu_layer_core: stimulus, backpressure and verdict.
module tb_conv1d_bias_relu_layer_core;
	timeunit 1ns;
	timeprecision 1ps;
	import c1d_pkg::*;

	localparam int NUM_FILTERS = DEF_NUM_FILTERS;
	localparam int NUM_TAPS    = DEF_NUM_TAPS;
	localparam int MAX_LENGTH  = DEF_MAX_LENGTH;

	typedef enum {RX_OPEN, RX_COIN, RX_CHOKE, RX_PERIODIC} rx_mode_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [APB_ADDR_W-1:0]    paddr = '0;
	logic [APB_DATA_W-1:0]    pwdata = '0;
	logic [APB_DATA_W-1:0]    prdata;
	logic                     pready;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [1:0]               opcode = OP_WEIGHT;
	logic [FIDX_W-1:0]        filter_index = '0;
	logic [TIDX_W-1:0]        tap_index = '0;
	logic signed [DATA_W-1:0] data_value = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [FIDX_W-1:0]        filter_out;
	logic [POS_W-1:0]         position;
	logic [ACT_W-1:0]         activation;
	logic                     last_of_run;

	int fail_count;
	int pending;
	int checked_count;
	int burst_left = 0;
	int items_sent = 0;
	int samples_sent = 0;
	rx_mode_t rx_mode = RX_OPEN;
	int rx_left = 0;

	conv1d_bias_relu_layer_core DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
		.filter_index(filter_index), .tap_index(tap_index), .data_value(data_value),
		.out_valid(out_valid), .out_ready(out_ready), .filter_out(filter_out),
		.position(position), .activation(activation), .last_of_run(last_of_run)
	);

	conv1d_layer_checker #(
		.FILTERS(NUM_FILTERS), .TAPS(NUM_TAPS), .MAX_LEN(MAX_LENGTH)
	) u_chk (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
		.filter_index(filter_index), .tap_index(tap_index), .data_value(data_value),
		.out_valid(out_valid), .out_ready(out_ready), .filter_out(filter_out),
		.position(position), .activation(activation), .last_of_run(last_of_run),
		.fail_count(fail_count), .pending(pending), .checked_count(checked_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver backpressure: the pattern is re-picked at random whenever its run ends
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(8, 200);
		end
		rx_left--;
		case (rx_mode)
			RX_OPEN: out_ready <= 1'b1;
			RX_COIN: out_ready <= ($urandom_range(0, 1) == 1);
			RX_CHOKE: out_ready <= ($urandom_range(0, 7) == 0);
			RX_PERIODIC: out_ready <= ((rx_left % 9) < 6);
		endcase
	end

	initial begin
		#30ms;
		$display("Timeout: results still pending = %0d", pending);
		$display("Some tests failed");
		$finish;
	end

	function automatic logic signed [DATA_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'sh0000;
			3: return -16'sd1;
			4, 5: return DATA_W'(int'($urandom_range(0, 127)) - 64);
			default: return DATA_W'($urandom);
		endcase
	endfunction

	task automatic send_request(input logic [1:0] op, input logic [FIDX_W-1:0] fi,
		input logic [TIDX_W-1:0] ti, input logic signed [DATA_W-1:0] d);
		int gap;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			gap = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 40) : $urandom_range(1, 3);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 8);
		end
		in_valid     <= 1'b1;
		opcode       <= op;
		filter_index <= fi;
		tap_index    <= ti;
		data_value   <= d;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		burst_left--;
		items_sent++;
	endtask

	task automatic send_sample(input logic signed [DATA_W-1:0] d);
		send_request(OP_SAMPLE, FIDX_W'($urandom), TIDX_W'($urandom), d);
		samples_sent++;
	endtask

	task automatic send_end();
		send_request(OP_END, FIDX_W'($urandom), TIDX_W'($urandom), DATA_W'($urandom));
	endtask

	// hold off until every expected result is out, then let the pipeline drain
	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic apb_cycle(input logic wr, input logic [APB_DATA_W-1:0] wdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= APB_ADDR_W'(4 * REG_FRAC_SHIFT);
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_frac(input logic [FRAC_W-1:0] v);
		logic [APB_DATA_W-1:0] wdata;
		wdata = APB_DATA_W'(v);
		if ($urandom_range(0, 1) == 1)
			wdata = wdata | ($urandom & ~APB_DATA_W'(5'h1f));
		apb_cycle(1'b1, wdata);
		apb_cycle(1'b0, '0);
	endtask

	initial begin : stimulus
		logic signed [DATA_W-1:0] wv;
		int seq_len;
		int phase_items;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_cycle(1'b0, '0);

		// fill every weight and bias first, so no entry is ever read unwritten
		for (int f = 0; f < NUM_FILTERS; f++) begin
			for (int k = 0; k < NUM_TAPS; k++) begin
				if (f == 0) wv = 16'sh7fff;
				else if (f == 1) wv = 16'sh8000;
				else wv = pick_word();
				send_request(OP_WEIGHT, FIDX_W'(f), TIDX_W'(k), wv);
			end
			case (f)
				2: wv = 16'sh8000;
				3: wv = 16'sh7fff;
				4: wv = '0;
				default: wv = pick_word();
			endcase
			send_request(OP_BIAS, FIDX_W'(f), TIDX_W'($urandom), wv);
		end

		// directed: empty end, ignored taps, short sequences, shift extremes
		send_end();
		send_request(OP_WEIGHT, 5'd31, 3'd5, 16'sh7fff);
		send_request(OP_WEIGHT, 5'd0, 3'd6, 16'sh8000);
		send_request(OP_WEIGHT, 5'd17, 3'd7, 16'sh1234);
		send_sample(16'sh7fff);
		send_end();
		send_sample(16'sh8000);
		send_sample(16'sh7fff);
		send_end();
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		send_sample(16'sh0000);
		send_sample(-16'sd1);
		send_sample(16'sd1);
		send_end();
		settle();
		set_frac(5'd0);
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		send_sample(16'sh7fff);
		send_end();
		settle();
		set_frac(5'd31);
		send_sample(16'sh8000);
		send_sample(16'sh8000);
		send_end();

		// short run at a middle shift
		settle();
		set_frac(5'd14);
		for (int i = 0; i < 4; i++) send_sample(pick_word());
		send_end();

		for (int ph = 0; ph < 4; ph++) begin
			settle();
			set_frac(ph == 0 ? FRAC_W'($urandom_range(12, 20)) : FRAC_W'($urandom_range(0, 31)));
			phase_items = 0;
			while (phase_items < 6) begin
				case ($urandom_range(0, 19))
					0, 1, 2: begin
						send_request(OP_WEIGHT, FIDX_W'($urandom),
							($urandom_range(0, 7) == 0) ? TIDX_W'($urandom_range(5, 7))
								: TIDX_W'($urandom_range(0, 4)), pick_word());
						phase_items++;
					end
					3, 4: begin
						send_request(OP_BIAS, FIDX_W'($urandom), TIDX_W'($urandom), pick_word());
						phase_items++;
					end
					5: begin
						send_end();
						phase_items++;
					end
					6: begin
						// unterminated sample: carries over into the next sequence
						send_sample(pick_word());
						phase_items++;
					end
					7: settle();
					default: begin
						seq_len = $urandom_range(1, 10);
						for (int i = 0; i < seq_len; i++) begin
							send_sample(pick_word());
							if ($urandom_range(0, 9) == 0)
								send_request(OP_BIAS, FIDX_W'($urandom), TIDX_W'($urandom),
									pick_word());
						end
						send_end();
						phase_items += seq_len + 1;
					end
				endcase
			end
		end

		settle();
		$display("Run summary: %0d requests (%0d samples), %0d activations checked.",
			items_sent, samples_sent, checked_count);
		$display("Shifts 8, 0, 31, 14 and random; empty, short and carried-over sequences.");
		if (fail_count == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
